[hw/rtl/relr_pkg.sv]
// Shared types and constants for the RELR relocation decoder.
// No dependencies; used by every module under hw/rtl.
package relr_pkg;

    localparam int ADDR_W           = 64;
    localparam int BITMAP_BITS_DEF  = 63;
    localparam int WORD_BYTES_DEF   = 8;
    localparam int CFG_INDEX_W      = 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE = 1'd1;

    localparam logic KIND_PROGRAM = 1'b0;
    localparam logic KIND_REBASE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR_PATCH,
        ST_ADDR_REBASE,
        ST_SCAN
    } relr_state_t;

    typedef enum logic {
        OPA_ENTRY,
        OPA_PLACE
    } relr_opa_t;

    typedef enum logic {
        OPB_OFFSET,
        OPB_STEP
    } relr_opb_t;

    typedef struct packed {
        relr_opa_t a_sel;
        relr_opb_t b_sel;
    } relr_alu_ctrl_t;

endpackage

[hw/rtl/relr_addr_unit.sv]
// Shared 64-bit address adder of the RELR decoder, operands chosen by the sequencer.
// Depends on relr_pkg.
module relr_addr_unit #(
    parameter int WORD_BYTES = relr_pkg::WORD_BYTES_DEF
) (
    input  relr_pkg::relr_alu_ctrl_t      ctrl,
    input  logic [relr_pkg::ADDR_W-1:0]   entry,
    input  logic [relr_pkg::ADDR_W-1:0]   place,
    input  logic [relr_pkg::ADDR_W-1:0]   offset,
    output logic [relr_pkg::ADDR_W-1:0]   sum
);
    import relr_pkg::*;

    logic [ADDR_W-1:0] op_a;
    logic [ADDR_W-1:0] op_b;

    always_comb
    begin
        unique case (ctrl.a_sel)
            OPA_ENTRY: op_a = entry;
            OPA_PLACE: op_a = place;
            default:   op_a = place;
        endcase
        unique case (ctrl.b_sel)
            OPB_OFFSET: op_b = offset;
            OPB_STEP:   op_b = ADDR_W'(WORD_BYTES);
            default:    op_b = ADDR_W'(WORD_BYTES);
        endcase
    end

    // wraps modulo 2^64
    assign sum = op_a + op_b;

endmodule

[hw/rtl/relr_relocation_decoder.sv]
// RELR relocation decoder: accepts one table entry per transfer and emits the byte
// addresses of the words to be relocated, one result per cycle through an output
// register while result_stall is low. An address entry gives two results and is
// handled as accept plus two adder passes; a bitmap entry is scanned one bitmap bit
// per cycle (BITMAP_BITS bits) while no set bit waits for the output register, because
// the single address adder steps the running place by one word per bit. Skipped entries
// (decoder disabled or offset zero) give no result and leave the decoder idle. A set
// bitmap bit waits while the output register is held; a bitmap bit that is clear is
// stepped past even then. New entries are stalled until the decoder is idle. Configuration
// writes are always taken and must arrive only while the decoder is idle.
// Depends on relr_pkg and relr_addr_unit.
module relr_relocation_decoder #(
    parameter int BITMAP_BITS = relr_pkg::BITMAP_BITS_DEF,
    parameter int WORD_BYTES  = relr_pkg::WORD_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [relr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [relr_pkg::ADDR_W-1:0]        cfg_data,
    // entry channel
    input  logic                               entry_valid,
    output logic                               entry_stall,
    input  logic [relr_pkg::ADDR_W-1:0]        entry_value,
    input  logic [relr_pkg::ADDR_W-1:0]        entry_address,
    input  logic                               end_of_table,
    // result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [relr_pkg::ADDR_W-1:0]        target_address,
    output logic                               patch_kind,
    output logic                               last_of_run
);
    import relr_pkg::*;

    localparam int CNT_W = (BITMAP_BITS > 1) ? $clog2(BITMAP_BITS) : 1;

    relr_state_t            state_reg, state_next;
    logic [ADDR_W-1:0]      offset_reg;
    logic                   enable_reg;
    logic [ADDR_W-1:0]      place_reg, place_next;
    logic [ADDR_W-1:0]      entry_reg, entry_next;
    logic [ADDR_W-1:0]      where_reg, where_next;
    logic                   last_reg, last_next;
    logic [BITMAP_BITS-1:0] bits_reg, bits_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic                   res_valid_reg;
    logic [ADDR_W-1:0]      res_addr_reg;
    logic                   res_kind_reg;
    logic                   res_last_reg;

    logic                   res_load;
    logic [ADDR_W-1:0]      res_addr_next;
    logic                   res_kind_next;
    logic                   res_last_next;

    relr_alu_ctrl_t         alu_ctrl;
    logic [ADDR_W-1:0]      alu_sum;
    logic                   slot_free;
    logic                   entry_take;
    logic                   active;

    relr_addr_unit #(
        .WORD_BYTES (WORD_BYTES)
    ) u_addr_unit (
        .ctrl   (alu_ctrl),
        .entry  (entry_reg),
        .place  (place_reg),
        .offset (offset_reg),
        .sum    (alu_sum)
    );

    assign cfg_ready      = 1'b1;
    assign entry_stall    = (state_reg != ST_IDLE);
    assign entry_take     = entry_valid && !entry_stall;
    assign active         = enable_reg && (offset_reg != '0);
    assign slot_free      = !res_valid_reg || !result_stall;

    assign result_valid   = res_valid_reg;
    assign target_address = res_addr_reg;
    assign patch_kind     = res_kind_reg;
    assign last_of_run    = res_last_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OFFSET: offset_reg <= cfg_data;
                CFG_ENABLE: enable_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            place_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            place_reg <= place_next;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (!result_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        where_reg <= where_next;
        last_reg  <= last_next;
        bits_reg  <= bits_next;
        cnt_reg   <= cnt_next;
        if (res_load)
        begin
            res_addr_reg <= res_addr_next;
            res_kind_reg <= res_kind_next;
            res_last_reg <= res_last_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        place_next     = place_reg;
        entry_next     = entry_reg;
        where_next     = where_reg;
        last_next      = last_reg;
        bits_next      = bits_reg;
        cnt_next       = cnt_reg;
        res_load       = 1'b0;
        res_addr_next  = alu_sum;
        res_kind_next  = KIND_PROGRAM;
        res_last_next  = 1'b0;
        alu_ctrl.a_sel = OPA_PLACE;
        alu_ctrl.b_sel = OPB_STEP;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (entry_take)
                begin
                    entry_next = entry_value;
                    where_next = entry_address;
                    last_next  = end_of_table;
                    bits_next  = entry_value[BITMAP_BITS:1];
                    cnt_next   = '0;
                    if (!active)
                    begin
                        if (end_of_table)
                            place_next = '0;
                    end
                    else if (entry_value[0])
                        state_next = ST_SCAN;
                    else
                        state_next = ST_ADDR_PATCH;
                end
            end

            ST_ADDR_PATCH:
            begin
                alu_ctrl.a_sel = OPA_ENTRY;
                alu_ctrl.b_sel = OPB_OFFSET;
                if (slot_free)
                begin
                    res_load      = 1'b1;
                    res_addr_next = alu_sum;
                    place_next    = alu_sum;   // patch address, stepped in ST_ADDR_REBASE unless end of table
                    state_next    = ST_ADDR_REBASE;
                end
            end

            ST_ADDR_REBASE:
            begin
                if (slot_free)
                begin
                    res_load      = 1'b1;
                    res_addr_next = where_reg;
                    res_kind_next = KIND_REBASE;
                    res_last_next = 1'b1;
                    place_next    = last_reg ? '0 : alu_sum;
                    state_next    = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // one bitmap bit per cycle; hold while a set bit finds the slot busy
                if (!bits_reg[0] || slot_free)
                begin
                    if (bits_reg[0])
                    begin
                        res_load      = 1'b1;
                        res_addr_next = place_reg;
                        res_last_next = (bits_reg[BITMAP_BITS-1:1] == '0);
                    end
                    bits_next  = bits_reg >> 1;
                    cnt_next   = cnt_reg + 1'b1;
                    place_next = alu_sum;
                    if (cnt_reg == CNT_W'(BITMAP_BITS - 1))
                    begin
                        if (last_reg)
                            place_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
